// ----- rtl/ktc_pkg.sv -----
package ktc_pkg;

    localparam int WINDOW_BYTES_DEF = 12;
    localparam int KW_MAX_LEN       = 12;
    localparam int KW_BITS          = 8 * KW_MAX_LEN;
    localparam int HIGH_WORDS       = 10;
    localparam int ELEV_WORDS       = 14;

    localparam logic [7:0] CHAR_LT     = 8'h3C;
    localparam logic [7:0] CHAR_GT     = 8'h3E;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam logic [1:0] CLASS_NORMAL   = 2'd0;
    localparam logic [1:0] CLASS_ELEVATED = 2'd1;
    localparam logic [1:0] CLASS_HIGH     = 2'd2;

    // keywords sit right-aligned: the last character is in bits [7:0]
    localparam bit [KW_BITS-1:0] HIGH_KW [HIGH_WORDS] = '{
        KW_BITS'("revolution"), KW_BITS'("hack"),    KW_BITS'("exploit"),
        KW_BITS'("attack"),     KW_BITS'("breach"),  KW_BITS'("overthrow"),
        KW_BITS'("destroy"),    KW_BITS'("weapon"),  KW_BITS'("war"),
        KW_BITS'("bomb")
    };
    localparam int HIGH_LEN [HIGH_WORDS] = '{10, 4, 7, 6, 6, 9, 7, 6, 3, 4};

    localparam bit [KW_BITS-1:0] ELEV_KW [ELEV_WORDS] = '{
        KW_BITS'("surveillance"), KW_BITS'("privacy"),  KW_BITS'("resistance"),
        KW_BITS'("protest"),      KW_BITS'("rebel"),    KW_BITS'("encrypt"),
        KW_BITS'("anonymous"),    KW_BITS'("leak"),     KW_BITS'("whistleblow"),
        KW_BITS'("dissent"),      KW_BITS'("activist"), KW_BITS'("censorship"),
        KW_BITS'("freedom"),      KW_BITS'("liberation")
    };
    localparam int ELEV_LEN [ELEV_WORDS] = '{12, 7, 10, 7, 5, 7, 9, 4, 11, 7, 8, 10, 7, 10};

    typedef struct packed {
        logic high;
        logic elev;
    } t_hits;

endpackage

// ----- rtl/ktc_match.sv -----
module ktc_match #(
    parameter int WINDOW_BYTES = ktc_pkg::WINDOW_BYTES_DEF
) (
    input  logic [8*WINDOW_BYTES-1:0] i_window,  // byte k at [8k+:8], newest at top
    output ktc_pkg::t_hits            o_hits
);
    import ktc_pkg::*;

    logic [HIGH_WORDS-1:0] w_high_hit;
    logic [ELEV_WORDS-1:0] w_elev_hit;

    // compare each keyword against the suffix of its own length, all in parallel
    always_comb begin
        for (int w = 0; w < HIGH_WORDS; w++) begin
            w_high_hit[w] = 1'b1;
            for (int j = 0; j < KW_MAX_LEN; j++) begin
                if (j < HIGH_LEN[w] &&
                    i_window[8*(WINDOW_BYTES-1-j) +: 8] != HIGH_KW[w][8*j +: 8]) begin
                    w_high_hit[w] = 1'b0;
                end
            end
        end
        for (int w = 0; w < ELEV_WORDS; w++) begin
            w_elev_hit[w] = 1'b1;
            for (int j = 0; j < KW_MAX_LEN; j++) begin
                if (j < ELEV_LEN[w] &&
                    i_window[8*(WINDOW_BYTES-1-j) +: 8] != ELEV_KW[w][8*j +: 8]) begin
                    w_elev_hit[w] = 1'b0;
                end
            end
        end
    end

    assign o_hits.high = |w_high_hit;
    assign o_hits.elev = |w_elev_hit;

endmodule

// ----- rtl/keyword_threat_classifier.sv -----
// A post's class appears on the master side once its final byte has passed the input
// register and the keyword match into the result register.
// Throughput: one byte per cycle; the keyword compare is one combinational pass.
// The input stage stalls only when it holds a final byte and the result is not taken.
// Reset (synchronous, active low) clears the window, match flags, tag state and valids.
module keyword_threat_classifier #(
    parameter int WINDOW_BYTES = ktc_pkg::WINDOW_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] text_byte
    input  logic       i_s_tlast,   // end_of_post
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [1:0] threat_class, [7:2] zero
);
    import ktc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_last;

    logic [7:0] r_recent [WINDOW_BYTES-1];
    logic       r_high;
    logic       r_elev;
    logic       r_inside;

    logic       r_out_valid;
    logic [1:0] r_class;

    logic                    w_consume;
    logic                    w_take;
    logic [7:0]              w_char;
    logic [8*WINDOW_BYTES-1:0] w_window;
    t_hits                   w_hits;
    logic                    n_high;
    logic                    n_elev;
    logic [1:0]              n_class;

    // a final byte may advance only if the result register is free
    assign w_consume  = r_in_valid && (!r_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_consume;

    assign w_take = (r_byte != CHAR_LT) && (r_byte != CHAR_GT) && !r_inside;
    assign w_char = (r_byte >= CHAR_UP_A && r_byte <= CHAR_UP_Z) ?
                    (r_byte + CASE_OFFSET) : r_byte;

    always_comb begin
        for (int k = 0; k < WINDOW_BYTES - 1; k++) begin
            w_window[8*k +: 8] = r_recent[k];
        end
        w_window[8*(WINDOW_BYTES-1) +: 8] = w_char;
    end

    ktc_match #(
        .WINDOW_BYTES(WINDOW_BYTES)
    ) u_match (
        .i_window(w_window),
        .o_hits  (w_hits)
    );

    assign n_high = r_high || (w_take && w_hits.high);
    assign n_elev = r_elev || (w_take && w_hits.elev);

    always_comb begin
        if (n_high) begin
            n_class = CLASS_HIGH;
        end else if (n_elev) begin
            n_class = CLASS_ELEVATED;
        end else begin
            n_class = CLASS_NORMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_byte <= i_s_tdata;
            r_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_BYTES - 1; k++) begin
                r_recent[k] <= '0;
            end
            r_high   <= 1'b0;
            r_elev   <= 1'b0;
            r_inside <= 1'b0;
        end else if (w_consume) begin
            if (r_last) begin
                // end of post: clear the window, match flags and tag state for the next one
                for (int k = 0; k < WINDOW_BYTES - 1; k++) begin
                    r_recent[k] <= '0;
                end
                r_high   <= 1'b0;
                r_elev   <= 1'b0;
                r_inside <= 1'b0;
            end else begin
                if (r_byte == CHAR_LT) begin
                    r_inside <= 1'b1;
                end else if (r_byte == CHAR_GT) begin
                    r_inside <= 1'b0;
                end
                if (w_take) begin
                    for (int k = 0; k < WINDOW_BYTES - 1; k++) begin
                        r_recent[k] <= w_window[8*(k+1) +: 8];
                    end
                end
                r_high <= n_high;
                r_elev <= n_elev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_consume && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_consume && r_last) begin
            r_class <= n_class;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_class};

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_last && r_out_valid && !i_m_tready))
        else $error("input stalled without a pending result");

    a_post_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && r_last) |=> (!r_high && !r_elev && !r_inside && o_m_tvalid))
        else $error("state not cleared or result missing after end of post");

    a_tag_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && !r_last && r_byte == CHAR_LT) |=> r_inside)
        else $error("opening bracket did not enter tag");

    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_class == CLASS_NORMAL || r_class == CLASS_ELEVATED ||
                        r_class == CLASS_HIGH))
        else $error("undefined class code");

endmodule
